// ----- rtl/round_robin_thread_scheduler_defines.svh -----
// Assertion macros used by the scheduler top module.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

// Condition holds at every edge out of reset.
`define RRTS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define RRTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rrts_pkg.sv -----
// Types and constants of the round-robin thread scheduler.
package rrts_pkg;

   localparam int MAX_THREADS_DEF = 16;

   localparam int FUNC_W   = 4;
   localparam int TID_W    = 4;
   localparam int SLOT_W   = 4;
   localparam int TOTAL_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FN_ADD     = 4'd0,
      FN_YIELD   = 4'd1,
      FN_BLOCK   = 4'd2,
      FN_UNBLOCK = 4'd3,
      FN_EXIT    = 4'd4,
      FN_TICK    = 4'd5,
      FN_DISABLE = 4'd6,
      FN_ENABLE  = 4'd7,
      FN_CLEAR   = 4'd8
   } func_type;

   typedef enum logic [1:0] {
      ST_READY    = 2'd0,
      ST_RUNNING  = 2'd1,
      ST_BLOCKED  = 2'd2,
      ST_FINISHED = 2'd3
   } slot_state_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_NORUN = 2'd2,
      STAT_BAD   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_NOP     = 2'd0,
      CELL_WRITE   = 2'd1,
      CELL_UNBLOCK = 2'd2,
      CELL_COMMIT  = 2'd3
   } cell_op_type;

   // Broadcast from the controller to every cell of the row.
   typedef struct packed {
      cell_op_type    op;
      slot_state_type wdata;
      logic           tok_load;
      logic           tok_shift;
   } cell_ctl_type;

endpackage

// ----- rtl/rrts_if.sv -----
// Valid/ready channel interfaces for scheduler events and results.
interface rrts_req_if
   import rrts_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [TID_W-1:0]  thread_id;
   logic              start_running;

   modport source (output valid, func, thread_id, start_running, input ready);
   modport sink   (input valid, func, thread_id, start_running, output ready);
endinterface

interface rrts_rsp_if
   import rrts_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   current_thread;
   logic [SLOT_W-1:0]   previous_thread;
   logic                switched;
   logic [TOTAL_W-1:0]  thread_total;
   logic                preempt_pending;
   logic [SLOT_W-1:0]   new_slot;
   logic [STATUS_W-1:0] status;

   modport source (output valid, current_thread, previous_thread, switched,
                   thread_total, preempt_pending, new_slot, status, input ready);
   modport sink   (input valid, current_thread, previous_thread, switched,
                   thread_total, preempt_pending, new_slot, status, output ready);
endinterface

// ----- rtl/rrts_cell.sv -----
// One thread slot: its state and the search token passing through it.
module rrts_cell
   import rrts_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF,
   parameter int ID          = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cell_ctl_type                         ctl,
   input  logic [$clog2(MAX_THREADS)-1:0]       idx_a,
   input  logic [$clog2(MAX_THREADS)-1:0]       idx_b,
   input  logic [$clog2(MAX_THREADS+1)-1:0]     count,
   input  logic                                 tok_i,
   output logic                                 tok_o,
   output logic                                 wrap_o,
   output logic                                 hit_o
);

   localparam int IDX_W = $clog2(MAX_THREADS);
   localparam int CNT_W = $clog2(MAX_THREADS + 1);
   localparam logic [IDX_W-1:0] MY_ID      = IDX_W'(ID);
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(ID + 1);

   slot_state_type state_ff, state_in;
   logic           tok_ff, tok_in;
   logic           is_last;

   assign is_last = (count == LAST_COUNT);

   always_comb begin
      state_in = state_ff;
      case (ctl.op)
         CELL_WRITE: begin
            if (idx_a == MY_ID) state_in = ctl.wdata;
         end
         CELL_UNBLOCK: begin
            if (idx_a == MY_ID && state_ff == ST_BLOCKED) state_in = ST_READY;
         end
         CELL_COMMIT: begin
            if (idx_a == MY_ID) begin
               state_in = ST_RUNNING;
            end else if (idx_b == MY_ID && state_ff == ST_RUNNING) begin
               state_in = ST_READY;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (ctl.tok_load) begin
         tok_in = (idx_b == MY_ID);
      end else if (ctl.tok_shift) begin
         tok_in = tok_i;
      end else begin
         tok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
      state_ff <= state_in;
   end

   assign tok_o  = tok_ff & ~is_last;
   assign wrap_o = tok_ff & is_last;
   assign hit_o  = tok_ff & (state_ff == ST_READY || state_ff == ST_RUNNING);

endmodule

// ----- rtl/rrts_chain.sv -----
// Row of slot cells with the wrapping token path of the round-robin search.
module rrts_chain
   import rrts_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cell_ctl_type                         ctl,
   input  logic [$clog2(MAX_THREADS)-1:0]       idx_a,
   input  logic [$clog2(MAX_THREADS)-1:0]       idx_b,
   input  logic [$clog2(MAX_THREADS+1)-1:0]     count,
   output logic [MAX_THREADS-1:0]               hit_vec,
   output logic                                 hit
);

   logic [MAX_THREADS-1:0] tok_in_vec;
   logic [MAX_THREADS-1:0] tok_out_vec;
   logic [MAX_THREADS-1:0] wrap_vec;

   // token leaves the last used slot and re-enters at slot 0
   assign tok_in_vec[0] = (|wrap_vec) | tok_out_vec[MAX_THREADS-1];

   for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
      if (i > 0) begin : g_link
         assign tok_in_vec[i] = tok_out_vec[i-1];
      end
      rrts_cell #(
         .MAX_THREADS (MAX_THREADS),
         .ID          (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .idx_a  (idx_a),
         .idx_b  (idx_b),
         .count  (count),
         .tok_i  (tok_in_vec[i]),
         .tok_o  (tok_out_vec[i]),
         .wrap_o (wrap_vec[i]),
         .hit_o  (hit_vec[i])
      );
   end

   assign hit = |hit_vec;

endmodule

// ----- rtl/round_robin_thread_scheduler.sv -----
// Round-robin thread scheduler: event controller over a row of slot cells.
// Each accepted event produces one result. Add, unblock, tick, preemption
// control, flag clear, unused codes and any reschedule that does not search
// (preemption off, or at most one slot in use) finish in the accept cycle
// and show a result on the next cycle. Yield, block and exit with preemption
// on and two or more slots start a search: a token walks the cell row one
// slot per cycle from the slot after the current one, wrapping at the last
// slot in use and visiting at most as many slots as are in use. Events are
// taken one at a time; a new event is accepted once the result register is
// free or being drained. Slot states need no clearing after reset.
module round_robin_thread_scheduler
   import rrts_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rrts_req_if.sink   req_bus,
   rrts_rsp_if.source rsp_bus
);

   `include "round_robin_thread_scheduler_defines.svh"

   localparam int IDX_W = $clog2(MAX_THREADS);
   localparam int CNT_W = $clog2(MAX_THREADS + 1);
   localparam int W4    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int W5    = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

   typedef enum logic {
      S_IDLE,
      S_SEARCH
   } ctrl_state_type;

   ctrl_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    cand_ff, cand_in;
   logic [IDX_W-1:0]    steps_ff, steps_in;
   logic                poff_ff, poff_in;
   logic                resched_ff, resched_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_cur_ff, rsp_cur_in;
   logic [SLOT_W-1:0]   rsp_prev_ff, rsp_prev_in;
   logic                rsp_sw_ff, rsp_sw_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;
   logic                rsp_pend_ff, rsp_pend_in;
   logic [SLOT_W-1:0]   rsp_new_ff, rsp_new_in;
   status_type          rsp_status_ff, rsp_status_in;

   cell_ctl_type           ctl;
   logic [IDX_W-1:0]       idx_a, idx_b;
   logic [MAX_THREADS-1:0] hit_vec;
   logic                   hit;

   logic                   req_xfer;
   logic                   do_resched;
   logic                   load_rsp;
   logic [IDX_W-1:0]       out_cur;
   logic [CNT_W-1:0]       out_new;
   status_type             out_status;
   logic [W4-1:0]          tid_w, out_cur_w, prev_w, out_new_w;
   logic [W5-1:0]          out_total_w;
   logic [CNT_W-1:0]       cur_p1, cand_p1, steps_w;
   logic [IDX_W-1:0]       cand0, cand_next;

   rrts_chain #(
      .MAX_THREADS (MAX_THREADS)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .idx_a   (idx_a),
      .idx_b   (idx_b),
      .count   (count_ff),
      .hit_vec (hit_vec),
      .hit     (hit)
   );

   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_xfer      = req_bus.valid && req_bus.ready;

   assign tid_w     = W4'(req_bus.thread_id);
   assign cur_p1    = CNT_W'(cur_ff) + CNT_W'(1);
   assign cand_p1   = CNT_W'(cand_ff) + CNT_W'(1);
   assign cand0     = (cur_p1 == count_ff) ? '0 : cur_p1[IDX_W-1:0];
   assign cand_next = (cand_p1 == count_ff) ? '0 : cand_p1[IDX_W-1:0];
   assign steps_w   = CNT_W'(steps_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      cand_in      = cand_ff;
      steps_in     = steps_ff;
      poff_in      = poff_ff;
      resched_in   = resched_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      ctl          = '{op: CELL_NOP, wdata: ST_READY, tok_load: 1'b0, tok_shift: 1'b0};
      idx_a        = '0;
      idx_b        = '0;
      do_resched   = 1'b0;
      load_rsp     = 1'b0;
      out_cur      = cur_ff;
      out_new      = '0;
      out_status   = STAT_OK;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (func_type'(req_bus.func))
                  FN_ADD: begin
                     if (count_ff == CNT_W'(MAX_THREADS)) begin
                        out_status = STAT_FULL;
                     end else begin
                        ctl.op    = CELL_WRITE;
                        ctl.wdata = req_bus.start_running ? ST_RUNNING : ST_READY;
                        idx_a     = count_ff[IDX_W-1:0];
                        out_new   = count_ff;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  FN_YIELD: begin
                     do_resched = 1'b1;
                  end
                  FN_BLOCK, FN_EXIT: begin
                     if (count_ff == '0) begin
                        out_status = STAT_BAD;
                     end else begin
                        ctl.op     = CELL_WRITE;
                        ctl.wdata  = (func_type'(req_bus.func) == FN_BLOCK) ?
                                     ST_BLOCKED : ST_FINISHED;
                        idx_a      = cur_ff;
                        do_resched = 1'b1;
                     end
                  end
                  FN_UNBLOCK: begin
                     if (tid_w >= W4'(count_ff)) begin
                        out_status = STAT_BAD;
                     end else begin
                        ctl.op = CELL_UNBLOCK;
                        idx_a  = tid_w[IDX_W-1:0];
                     end
                  end
                  FN_TICK: begin
                     if (!poff_ff) resched_in = 1'b1;
                  end
                  FN_DISABLE: begin
                     poff_in = 1'b1;
                  end
                  FN_ENABLE: begin
                     poff_in = 1'b0;
                  end
                  FN_CLEAR: begin
                     resched_in = 1'b0;
                  end
                  default: begin
                  end
               endcase

               if (do_resched && !poff_ff && count_ff > CNT_W'(1)) begin
                  resched_in   = 1'b0;
                  ctl.tok_load = 1'b1;
                  idx_b        = cand0;
                  cand_in      = cand0;
                  steps_in     = '0;
                  state_in     = S_SEARCH;
               end else begin
                  if (do_resched && !poff_ff) resched_in = 1'b0;
                  load_rsp = 1'b1;
               end
            end
         end
         S_SEARCH: begin
            if (hit) begin
               ctl.op   = CELL_COMMIT;
               idx_a    = cand_ff;
               idx_b    = cur_ff;
               cur_in   = cand_ff;
               out_cur  = cand_ff;
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end else if (steps_w == count_ff - CNT_W'(1)) begin
               out_status = STAT_NORUN;
               load_rsp   = 1'b1;
               state_in   = S_IDLE;
            end else begin
               ctl.tok_shift = 1'b1;
               cand_in       = cand_next;
               steps_in      = steps_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load_rsp) rsp_valid_in = 1'b1;
   end

   assign out_cur_w   = W4'(out_cur);
   assign prev_w      = W4'(cur_ff);
   assign out_new_w   = W4'(out_new);
   assign out_total_w = W5'(count_in);

   assign rsp_cur_in    = load_rsp ? out_cur_w[SLOT_W-1:0] : rsp_cur_ff;
   assign rsp_prev_in   = load_rsp ? prev_w[SLOT_W-1:0] : rsp_prev_ff;
   assign rsp_sw_in     = load_rsp ? (out_cur != cur_ff) : rsp_sw_ff;
   assign rsp_total_in  = load_rsp ? out_total_w[TOTAL_W-1:0] : rsp_total_ff;
   assign rsp_pend_in   = load_rsp ? resched_in : rsp_pend_ff;
   assign rsp_new_in    = load_rsp ? out_new_w[SLOT_W-1:0] : rsp_new_ff;
   assign rsp_status_in = load_rsp ? out_status : rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cur_ff       <= '0;
         poff_ff      <= 1'b0;
         resched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         poff_ff      <= poff_in;
         resched_ff   <= resched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff       <= cand_in;
      steps_ff      <= steps_in;
      rsp_cur_ff    <= rsp_cur_in;
      rsp_prev_ff   <= rsp_prev_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_pend_ff   <= rsp_pend_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.current_thread  = rsp_cur_ff;
   assign rsp_bus.previous_thread = rsp_prev_ff;
   assign rsp_bus.switched        = rsp_sw_ff;
   assign rsp_bus.thread_total    = rsp_total_ff;
   assign rsp_bus.preempt_pending = rsp_pend_ff;
   assign rsp_bus.new_slot        = rsp_new_ff;
   assign rsp_bus.status          = rsp_status_ff;

   `RRTS_ASSERT_IMPL(a_cur_in_range, clock, reset, count_ff != '0, CNT_W'(cur_ff) < count_ff, "current slot outside table")
   `RRTS_ASSERT_ALWAYS(a_single_hit, clock, reset, $onehot0(hit_vec), "more than one cell holds the token")
   `RRTS_ASSERT_IMPL(a_search_bound, clock, reset, state_ff == S_SEARCH, steps_w < count_ff, "search ran past table")
   `RRTS_ASSERT_IMPL(a_search_rsp_free, clock, reset, state_ff == S_SEARCH, !rsp_valid_ff, "search with result register busy")
   `RRTS_ASSERT_NEXT(a_hit_done, clock, reset, state_ff == S_SEARCH && hit, rsp_valid_ff && state_ff == S_IDLE, "hit did not end search")

endmodule

// ----- tb/tb_round_robin_thread_scheduler.sv -----
// Self-checking testbench of the round-robin thread scheduler.
module tb_round_robin_thread_scheduler;
   import rrts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int                N_THREADS   = MAX_THREADS_DEF;
   localparam int                N_RANDOM    = 750;
   localparam int                HOLD_AT     = 250;
   localparam int                DRAIN_AT    = 500;
   localparam int                HOLD_CYCLES = 400;
   localparam int                CYCLE_LIMIT = 300000;
   localparam logic [FUNC_W-1:0] FN_UNUSED   = 4'd15;

   typedef struct packed {
      logic [SLOT_W-1:0]  cur;
      logic [SLOT_W-1:0]  prev;
      logic               sw;
      logic [TOTAL_W-1:0] total;
      logic               pend;
      logic [SLOT_W-1:0]  nslot;
      status_type         stat;
   } outcome_type;

   typedef struct packed {
      logic [FUNC_W-1:0] fn;
      logic [TID_W-1:0]  tid;
      logic              start;
      logic              typed;
      outcome_type       want;
   } stim_row_type;

   localparam outcome_type PREDICT = '0;
   localparam int          N_DIRECTED = 29;

   // Known outcomes typed in for the empty table, first adds and error codes.
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{FN_YIELD,   4'd0,  1'b0, 1'b1, '{4'd0, 4'd0, 1'b0, 5'd0, 1'b0, 4'd0, STAT_OK}},
      '{FN_BLOCK,   4'd0,  1'b0, 1'b1, '{4'd0, 4'd0, 1'b0, 5'd0, 1'b0, 4'd0, STAT_BAD}},
      '{FN_EXIT,    4'd5,  1'b1, 1'b1, '{4'd0, 4'd0, 1'b0, 5'd0, 1'b0, 4'd0, STAT_BAD}},
      '{FN_UNBLOCK, 4'd15, 1'b0, 1'b1, '{4'd0, 4'd0, 1'b0, 5'd0, 1'b0, 4'd0, STAT_BAD}},
      '{FN_TICK,    4'd0,  1'b0, 1'b1, '{4'd0, 4'd0, 1'b0, 5'd0, 1'b1, 4'd0, STAT_OK}},
      '{FN_YIELD,   4'd0,  1'b0, 1'b1, '{4'd0, 4'd0, 1'b0, 5'd0, 1'b0, 4'd0, STAT_OK}},
      '{FN_TICK,    4'd0,  1'b0, 1'b1, '{4'd0, 4'd0, 1'b0, 5'd0, 1'b1, 4'd0, STAT_OK}},
      '{FN_CLEAR,   4'd0,  1'b0, 1'b1, '{4'd0, 4'd0, 1'b0, 5'd0, 1'b0, 4'd0, STAT_OK}},
      '{FN_UNUSED,  4'd15, 1'b1, 1'b1, '{4'd0, 4'd0, 1'b0, 5'd0, 1'b0, 4'd0, STAT_OK}},
      '{FN_DISABLE, 4'd10, 1'b1, 1'b0, PREDICT},
      '{FN_TICK,    4'd0,  1'b0, 1'b0, PREDICT},
      '{FN_ENABLE,  4'd5,  1'b0, 1'b0, PREDICT},
      '{FN_ADD,     4'd0,  1'b1, 1'b1, '{4'd0, 4'd0, 1'b0, 5'd1, 1'b0, 4'd0, STAT_OK}},
      '{FN_TICK,    4'd0,  1'b0, 1'b0, PREDICT},
      '{FN_YIELD,   4'd0,  1'b0, 1'b0, PREDICT},
      '{FN_ADD,     4'd15, 1'b0, 1'b1, '{4'd0, 4'd0, 1'b0, 5'd2, 1'b0, 4'd1, STAT_OK}},
      '{FN_ADD,     4'd0,  1'b0, 1'b0, PREDICT},
      '{FN_BLOCK,   4'd0,  1'b0, 1'b0, PREDICT},
      '{FN_UNBLOCK, 4'd2,  1'b0, 1'b0, PREDICT},
      '{FN_UNBLOCK, 4'd3,  1'b0, 1'b1, '{4'd1, 4'd1, 1'b0, 5'd3, 1'b0, 4'd0, STAT_BAD}},
      '{FN_EXIT,    4'd0,  1'b0, 1'b0, PREDICT},
      '{FN_BLOCK,   4'd0,  1'b0, 1'b0, PREDICT},
      '{FN_UNBLOCK, 4'd0,  1'b1, 1'b0, PREDICT},
      '{FN_TICK,    4'd0,  1'b0, 1'b0, PREDICT},
      '{FN_DISABLE, 4'd0,  1'b0, 1'b0, PREDICT},
      '{FN_YIELD,   4'd0,  1'b0, 1'b0, PREDICT},
      '{FN_ENABLE,  4'd0,  1'b0, 1'b0, PREDICT},
      '{FN_YIELD,   4'd0,  1'b0, 1'b0, PREDICT},
      '{FN_UNBLOCK, 4'd2,  1'b0, 1'b0, PREDICT}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   rrts_req_if req_bus ();
   rrts_rsp_if rsp_bus ();

   round_robin_thread_scheduler i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #10 clock = ~clock;

   // Scheduler state as the testbench sees it
   slot_state_type  sched_slot [N_THREADS];
   int              sched_cur;
   int              sched_count;
   bit              sched_preempt_off;
   bit              sched_resched;

   outcome_type     outcome_q [$];
   int              errors;
   int              cycle_count;
   bit              hold_req;

   function automatic status_type rotate_to_next();
      int prev;
      int cand;
      if (sched_preempt_off)
         return STAT_OK;
      sched_resched = 1'b0;
      if (sched_count <= 1)
         return STAT_OK;
      prev = sched_cur;
      cand = prev;
      for (int n = 0; n < sched_count; n++) begin
         cand = (cand + 1) % sched_count;
         if (sched_slot[cand] == ST_READY || sched_slot[cand] == ST_RUNNING) begin
            if (sched_slot[prev] == ST_RUNNING)
               sched_slot[prev] = ST_READY;
            sched_slot[cand] = ST_RUNNING;
            sched_cur = cand;
            return STAT_OK;
         end
      end
      return STAT_NORUN;
   endfunction

   function automatic outcome_type schedule_event(logic [FUNC_W-1:0] fn,
                                                  logic [TID_W-1:0] tid, logic start);
      outcome_type res;
      int          prev;
      int          added;
      status_type  stat;
      prev  = sched_cur;
      added = 0;
      stat  = STAT_OK;
      case (fn)
         FN_ADD: begin
            if (sched_count >= N_THREADS) begin
               stat = STAT_FULL;
            end else begin
               sched_slot[sched_count] = start ? ST_RUNNING : ST_READY;
               added = sched_count;
               sched_count++;
            end
         end
         FN_YIELD: stat = rotate_to_next();
         FN_BLOCK, FN_EXIT: begin
            if (sched_count == 0) begin
               stat = STAT_BAD;
            end else begin
               sched_slot[sched_cur] = (fn == FN_BLOCK) ? ST_BLOCKED : ST_FINISHED;
               stat = rotate_to_next();
            end
         end
         FN_UNBLOCK: begin
            if (int'(tid) >= sched_count)
               stat = STAT_BAD;
            else if (sched_slot[tid] == ST_BLOCKED)
               sched_slot[tid] = ST_READY;
         end
         FN_TICK: begin
            if (!sched_preempt_off)
               sched_resched = 1'b1;
         end
         FN_DISABLE: sched_preempt_off = 1'b1;
         FN_ENABLE:  sched_preempt_off = 1'b0;
         FN_CLEAR:   sched_resched = 1'b0;
         default: ;
      endcase
      res.cur   = sched_cur[SLOT_W-1:0];
      res.prev  = prev[SLOT_W-1:0];
      res.sw    = (sched_cur != prev);
      res.total = sched_count[TOTAL_W-1:0];
      res.pend  = sched_resched;
      res.nslot = added[SLOT_W-1:0];
      res.stat  = stat;
      return res;
   endfunction

   task automatic offer_event(logic [FUNC_W-1:0] fn, logic [TID_W-1:0] tid, logic start);
      req_bus.valid         <= 1'b1;
      req_bus.func          <= fn;
      req_bus.thread_id     <= tid;
      req_bus.start_running <= start;
      do
         @(posedge clock);
      while (!req_bus.ready);
   endtask

   // Event source
   initial begin : req_side
      outcome_type       pred;
      logic [FUNC_W-1:0] fn;
      logic [TID_W-1:0]  tid;
      int                r;
      int                burst_left;
      int                gap;
      int                done_slots;
      req_bus.valid         = 1'b0;
      req_bus.func          = '0;
      req_bus.thread_id     = '0;
      req_bus.start_running = 1'b0;
      for (int i = 0; i < N_THREADS; i++)
         sched_slot[i] = ST_READY;
      sched_cur         = 0;
      sched_count       = 0;
      sched_preempt_off = 1'b0;
      sched_resched     = 1'b0;
      hold_req          = 1'b0;
      burst_left        = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_event(directed_rows[i].fn, directed_rows[i].tid, directed_rows[i].start);
         pred = schedule_event(directed_rows[i].fn, directed_rows[i].tid,
                               directed_rows[i].start);
         outcome_q = {outcome_q, (directed_rows[i].typed ? directed_rows[i].want : pred)};
      end

      for (int k = 0; k < N_RANDOM; k++) begin
         if (k == HOLD_AT)
            hold_req = 1'b1;
         if (k == DRAIN_AT) begin
            req_bus.valid <= 1'b0;
            while (outcome_q.size() != 0)
               @(posedge clock);
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         if (burst_left > 0)
            burst_left--;

         tid = TID_W'($urandom_range(0, 15));
         r   = $urandom_range(0, 99);
         if (r < 8)
            fn = FN_ADD;
         else if (r < 23)
            fn = FN_YIELD;
         else if (r < 38)
            fn = FN_BLOCK;
         else if (r < 63)
            fn = FN_UNBLOCK;
         else if (r < 66)
            fn = FN_EXIT;
         else if (r < 76)
            fn = FN_TICK;
         else if (r < 82)
            fn = FN_DISABLE;
         else if (r < 92)
            fn = FN_ENABLE;
         else if (r < 97)
            fn = FN_CLEAR;
         else
            fn = FUNC_W'($urandom_range(9, 15));

         // Keep exits rare so most slots stay schedulable
         if (fn == FN_EXIT) begin
            done_slots = 0;
            for (int i = 0; i < sched_count; i++)
               if (sched_slot[i] == ST_FINISHED)
                  done_slots++;
            if (done_slots >= 10)
               fn = FN_YIELD;
         end
         // Mostly unblock slots in use, preferring blocked ones
         if (fn == FN_UNBLOCK && sched_count > 0 && $urandom_range(0, 9) < 8) begin
            for (int t = 0; t < 4; t++) begin
               tid = TID_W'($urandom_range(0, sched_count - 1));
               if (sched_slot[tid] == ST_BLOCKED)
                  break;
            end
         end

         offer_event(fn, tid, 1'($urandom_range(0, 1)));
         outcome_q = {outcome_q, schedule_event(req_bus.func, req_bus.thread_id,
                                                req_bus.start_running)};
      end

      req_bus.valid <= 1'b0;
      while (outcome_q.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Result sink with its own stall pattern
   initial begin : rsp_side
      int hold_cnt;
      int mode;
      int mode_left;
      int phase;
      rsp_bus.ready = 1'b0;
      hold_cnt  = 0;
      mode      = 0;
      mode_left = 0;
      phase     = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 150);
         end
         mode_left--;
         phase++;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= (phase % 3 == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // Result checker
   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (outcome_q.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_bus.current_thread !== want.cur) begin
               $error("current_thread: expected %0d, got %0d", want.cur,
                      rsp_bus.current_thread);
               errors++;
            end
            if (rsp_bus.previous_thread !== want.prev) begin
               $error("previous_thread: expected %0d, got %0d", want.prev,
                      rsp_bus.previous_thread);
               errors++;
            end
            if (rsp_bus.switched !== want.sw) begin
               $error("switched: expected %0d, got %0d", want.sw, rsp_bus.switched);
               errors++;
            end
            if (rsp_bus.thread_total !== want.total) begin
               $error("thread_total: expected %0d, got %0d", want.total,
                      rsp_bus.thread_total);
               errors++;
            end
            if (rsp_bus.preempt_pending !== want.pend) begin
               $error("preempt_pending: expected %0d, got %0d", want.pend,
                      rsp_bus.preempt_pending);
               errors++;
            end
            if (rsp_bus.new_slot !== want.nslot) begin
               $error("new_slot: expected %0d, got %0d", want.nslot, rsp_bus.new_slot);
               errors++;
            end
            if (rsp_bus.status !== want.stat) begin
               $error("status: expected %0d, got %0d", want.stat, rsp_bus.status);
               errors++;
            end
         end
      end
   end

   initial begin
      errors      = 0;
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

// ----- round_robin_thread_scheduler.f -----
+incdir+rtl
rtl/rrts_pkg.sv
rtl/rrts_if.sv
rtl/rrts_cell.sv
rtl/rrts_chain.sv
rtl/round_robin_thread_scheduler.sv
tb/tb_round_robin_thread_scheduler.sv
